>>> rtl/cau_pkg.sv
package cau_pkg;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    localparam int MAG_W = 64;
    localparam int NUM_W = 128;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
    } cau_ctl_t;

endpackage

>>> rtl/complex_arith_unit.sv
// Channel  | Handshake           | Fields
// ---------+---------------------+--------------------------------------
// input    | start, busy         | kind, a_re, a_im, b_re, b_im
// result   | done (one cycle)    | res_re, res_im, div_zero, overflow
//
// One item enters per cycle; busy is always low. Each result passes two
// product stages, the 32-stage restoring divider with four quotient bits
// per stage, and one saturation stage. Every operation takes the same path
// so results leave in order, and the receiver cannot stall the pipeline.
// Reset clears only the valid bits, plus the kind fields in the divider.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               done,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               div_zero,
    output logic               overflow
);

    cau_ctl_t         p_ctl;
    logic             p_neg_re;
    logic             p_neg_im;
    logic [MAG_W-1:0] p_mag_re;
    logic [MAG_W-1:0] p_mag_im;
    logic [MAG_W-1:0] p_den;
    cau_ctl_t         d_ctl;
    logic             d_neg_re;
    logic             d_neg_im;
    logic [MAG_W-1:0] d_mag_re;
    logic [MAG_W-1:0] d_mag_im;
    logic [MAG_W-1:0] d_hi_re;
    logic [MAG_W-1:0] d_hi_im;
    logic             d_dz;

    assign busy = 1'b0;

    cau_prod u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .in_kind  (kind),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .ctl      (p_ctl),
        .neg_re   (p_neg_re),
        .mag_re   (p_mag_re),
        .neg_im   (p_neg_im),
        .mag_im   (p_mag_im),
        .den      (p_den)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (p_ctl),
        .in_neg_re  (p_neg_re),
        .in_mag_re  (p_mag_re),
        .in_neg_im  (p_neg_im),
        .in_mag_im  (p_mag_im),
        .in_den     (p_den),
        .out_ctl    (d_ctl),
        .out_neg_re (d_neg_re),
        .out_mag_re (d_mag_re),
        .out_hi_re  (d_hi_re),
        .out_neg_im (d_neg_im),
        .out_mag_im (d_mag_im),
        .out_hi_im  (d_hi_im),
        .out_dz     (d_dz)
    );

    cau_sat #(.FRAC_BITS(FRAC_BITS)) u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (d_ctl),
        .in_neg_re (d_neg_re),
        .in_mag_re (d_mag_re),
        .in_hi_re  (d_hi_re),
        .in_neg_im (d_neg_im),
        .in_mag_im (d_mag_im),
        .in_hi_im  (d_hi_im),
        .in_dz     (d_dz),
        .done      (done),
        .res_re    (res_re),
        .res_im    (res_im),
        .div_zero  (div_zero),
        .overflow  (overflow)
    );

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && div_zero |-> res_re == 0 && res_im == 0 && !overflow)
        else $error("zero divisor result not cleared");

    a_start_flows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##35 done)
        else $error("start not captured");

    a_dz_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        d_dz |-> d_ctl.kind == KIND_DIV)
        else $error("zero divisor flagged on non-divide");

endmodule

>>> rtl/cau_prod.sv
module cau_prod
    import cau_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_kind,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output cau_ctl_t            ctl,
    output logic                neg_re,
    output logic [MAG_W-1:0]    mag_re,
    output logic                neg_im,
    output logic [MAG_W-1:0]    mag_im,
    output logic [MAG_W-1:0]    den
);

    logic                       s1_valid_reg;
    logic [1:0]                 s1_kind_reg;
    logic signed [63:0]         p_rr_reg;
    logic signed [63:0]         p_ii_reg;
    logic signed [63:0]         p_ir_reg;
    logic signed [63:0]         p_ri_reg;
    logic [63:0]                sq_r_reg;
    logic [63:0]                sq_i_reg;

    logic signed [64:0]         sum_re_next;
    logic signed [64:0]         sum_im_next;
    logic signed [64:0]         x_re;
    logic signed [64:0]         x_im;
    logic                       s2_valid_reg;
    logic [1:0]                 s2_kind_reg;
    logic                       neg_re_reg;
    logic                       neg_im_reg;
    logic [MAG_W-1:0]           mag_re_reg;
    logic [MAG_W-1:0]           mag_im_reg;
    logic [MAG_W-1:0]           den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= in_kind;
        if (in_kind == KIND_ADD || in_kind == KIND_SUB)
        begin
            p_rr_reg <= 64'(a_re);
            p_ii_reg <= 64'(a_im);
            p_ir_reg <= 64'(b_re);
            p_ri_reg <= 64'(b_im);
        end
        else
        begin
            p_rr_reg <= a_re * b_re;
            p_ii_reg <= a_im * b_im;
            p_ir_reg <= a_im * b_re;
            p_ri_reg <= a_re * b_im;
        end
        sq_r_reg <= b_re * b_re;
        sq_i_reg <= b_im * b_im;
    end

    always_comb
    begin
        case (s1_kind_reg)
            KIND_ADD:
            begin
                sum_re_next = 65'(p_rr_reg) + 65'(p_ir_reg);
                sum_im_next = 65'(p_ii_reg) + 65'(p_ri_reg);
            end
            KIND_SUB:
            begin
                sum_re_next = 65'(p_rr_reg) - 65'(p_ir_reg);
                sum_im_next = 65'(p_ii_reg) - 65'(p_ri_reg);
            end
            KIND_MUL:
            begin
                sum_re_next = 65'(p_rr_reg) - 65'(p_ii_reg);
                sum_im_next = 65'(p_ir_reg) + 65'(p_ri_reg);
            end
            default:
            begin
                sum_re_next = 65'(p_rr_reg) + 65'(p_ii_reg);
                sum_im_next = 65'(p_ir_reg) - 65'(p_ri_reg);
            end
        endcase
        x_re = sum_re_next[64] ? -sum_re_next : sum_re_next;
        x_im = sum_im_next[64] ? -sum_im_next : sum_im_next;
    end

    always_ff @(posedge clk)
    begin
        s2_kind_reg <= s1_kind_reg;
        neg_re_reg  <= sum_re_next[64];
        neg_im_reg  <= sum_im_next[64];
        mag_re_reg  <= x_re[MAG_W-1:0];
        mag_im_reg  <= x_im[MAG_W-1:0];
        den_reg     <= sq_r_reg + sq_i_reg;
    end

    assign ctl.valid = s2_valid_reg;
    assign ctl.kind  = s2_kind_reg;
    assign neg_re    = neg_re_reg;
    assign neg_im    = neg_im_reg;
    assign mag_re    = mag_re_reg;
    assign mag_im    = mag_im_reg;
    assign den       = den_reg;

endmodule

>>> rtl/cau_div.sv
module cau_div
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cau_ctl_t         in_ctl,
    input  logic             in_neg_re,
    input  logic [MAG_W-1:0] in_mag_re,
    input  logic             in_neg_im,
    input  logic [MAG_W-1:0] in_mag_im,
    input  logic [MAG_W-1:0] in_den,
    output cau_ctl_t         out_ctl,
    output logic             out_neg_re,
    output logic [MAG_W-1:0] out_mag_re,
    output logic [MAG_W-1:0] out_hi_re,
    output logic             out_neg_im,
    output logic [MAG_W-1:0] out_mag_im,
    output logic [MAG_W-1:0] out_hi_im,
    output logic             out_dz
);

    localparam int STEPS  = NUM_W;
    localparam int PER    = 4;
    localparam int STAGES = STEPS / PER;
    localparam int REM_W  = MAG_W + 1;

    cau_ctl_t           ctl_reg   [STAGES+1];
    logic               neg_r_reg [STAGES+1];
    logic               neg_i_reg [STAGES+1];
    logic [MAG_W-1:0]   orig_r_reg[STAGES+1];
    logic [MAG_W-1:0]   orig_i_reg[STAGES+1];
    logic [MAG_W-1:0]   den_reg   [STAGES+1];
    logic [NUM_W-1:0]   num_r_reg [STAGES+1];
    logic [NUM_W-1:0]   num_i_reg [STAGES+1];
    logic [REM_W-1:0]   rem_r_reg [STAGES+1];
    logic [REM_W-1:0]   rem_i_reg [STAGES+1];

    always_comb
    begin
        ctl_reg[0]    = in_ctl;
        neg_r_reg[0]  = in_neg_re;
        neg_i_reg[0]  = in_neg_im;
        orig_r_reg[0] = in_mag_re;
        orig_i_reg[0] = in_mag_im;
        den_reg[0]    = in_den;
        num_r_reg[0]  = {{(NUM_W-MAG_W-FRAC_BITS){1'b0}}, in_mag_re, {FRAC_BITS{1'b0}}};
        num_i_reg[0]  = {{(NUM_W-MAG_W-FRAC_BITS){1'b0}}, in_mag_im, {FRAC_BITS{1'b0}}};
        rem_r_reg[0]  = '0;
        rem_i_reg[0]  = '0;
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [REM_W-1:0] r_r;
        logic [REM_W-1:0] r_i;
        logic [NUM_W-1:0] n_r;
        logic [NUM_W-1:0] n_i;

        always_comb
        begin
            r_r = rem_r_reg[s];
            r_i = rem_i_reg[s];
            n_r = num_r_reg[s];
            n_i = num_i_reg[s];
            for (int k = 0; k < PER; k++)
            begin
                r_r = {r_r[REM_W-2:0], n_r[NUM_W-1]};
                r_i = {r_i[REM_W-2:0], n_i[NUM_W-1]};
                n_r = {n_r[NUM_W-2:0], 1'b0};
                n_i = {n_i[NUM_W-2:0], 1'b0};
                if (r_r >= {1'b0, den_reg[s]})
                begin
                    r_r = r_r - {1'b0, den_reg[s]};
                    n_r[0] = 1'b1;
                end
                if (r_i >= {1'b0, den_reg[s]})
                begin
                    r_i = r_i - {1'b0, den_reg[s]};
                    n_i[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_r_reg[s+1]    <= neg_r_reg[s];
            neg_i_reg[s+1]    <= neg_i_reg[s];
            orig_r_reg[s+1]   <= orig_r_reg[s];
            orig_i_reg[s+1]   <= orig_i_reg[s];
            den_reg[s+1]      <= den_reg[s];
            if (ctl_reg[s].kind == KIND_DIV)
            begin
                num_r_reg[s+1] <= n_r;
                num_i_reg[s+1] <= n_i;
                rem_r_reg[s+1] <= r_r;
                rem_i_reg[s+1] <= r_i;
            end
            else
            begin
                num_r_reg[s+1] <= num_r_reg[s];
                num_i_reg[s+1] <= num_i_reg[s];
                rem_r_reg[s+1] <= rem_r_reg[s];
                rem_i_reg[s+1] <= rem_i_reg[s];
            end
        end
    end

    assign out_ctl    = ctl_reg[STAGES];
    assign out_neg_re = neg_r_reg[STAGES];
    assign out_neg_im = neg_i_reg[STAGES];
    assign out_dz     = (ctl_reg[STAGES].kind == KIND_DIV) && (den_reg[STAGES] == '0);
    assign out_mag_re = (ctl_reg[STAGES].kind == KIND_DIV) ? num_r_reg[STAGES][MAG_W-1:0]
                                                           : orig_r_reg[STAGES];
    assign out_mag_im = (ctl_reg[STAGES].kind == KIND_DIV) ? num_i_reg[STAGES][MAG_W-1:0]
                                                           : orig_i_reg[STAGES];
    assign out_hi_re  = (ctl_reg[STAGES].kind == KIND_DIV) ? num_r_reg[STAGES][NUM_W-1:MAG_W]
                                                           : '0;
    assign out_hi_im  = (ctl_reg[STAGES].kind == KIND_DIV) ? num_i_reg[STAGES][NUM_W-1:MAG_W]
                                                           : '0;

endmodule

>>> rtl/cau_sat.sv
module cau_sat
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cau_ctl_t           in_ctl,
    input  logic               in_neg_re,
    input  logic [MAG_W-1:0]   in_mag_re,
    input  logic [MAG_W-1:0]   in_hi_re,
    input  logic               in_neg_im,
    input  logic [MAG_W-1:0]   in_mag_im,
    input  logic [MAG_W-1:0]   in_hi_im,
    input  logic               in_dz,
    output logic               done,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               div_zero,
    output logic               overflow
);

    logic               done_reg;
    logic [31:0]        re_reg;
    logic [31:0]        im_reg;
    logic               dz_reg;
    logic               ovf_reg;
    logic [31:0]        re_next;
    logic [31:0]        im_next;
    logic               ovf_re;
    logic               ovf_im;

    function automatic logic [32:0] sat_part(input logic [1:0] kind, input logic neg,
                                             input logic [MAG_W-1:0] mag,
                                             input logic [MAG_W-1:0] hi);
        logic [MAG_W-1:0] q;
        logic             n;
        logic [32:0]      r;
        if (kind == KIND_MUL)
        begin
            q = neg ? ((mag + MAG_W'((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS)
                    : (mag >> FRAC_BITS);
        end
        else
        begin
            q = mag;
        end
        n = neg && (q != '0 || hi != '0);
        if (!n)
        begin
            if (hi != '0 || q > MAG_W'(32'h7FFFFFFF))
                r = {1'b1, 32'h7FFFFFFF};
            else
                r = {1'b0, q[31:0]};
        end
        else
        begin
            if (hi != '0 || q > MAG_W'(33'h080000000))
                r = {1'b1, 32'h80000000};
            else
                r = {1'b0, 32'(-q[31:0])};
        end
        return r;
    endfunction

    always_comb
    begin
        {ovf_re, re_next} = sat_part(in_ctl.kind, in_neg_re, in_mag_re, in_hi_re);
        {ovf_im, im_next} = sat_part(in_ctl.kind, in_neg_im, in_mag_im, in_hi_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg  <= in_dz ? '0 : re_next;
        im_reg  <= in_dz ? '0 : im_next;
        dz_reg  <= in_dz;
        ovf_reg <= !in_dz && (ovf_re || ovf_im);
    end

    assign done     = done_reg;
    assign res_re   = re_reg;
    assign res_im   = im_reg;
    assign div_zero = dz_reg;
    assign overflow = ovf_reg;

endmodule

>>> sim/tb_top.sv
module tb_top;
    import cau_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 35;
    localparam int N_RANDOM = 930;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               dz;
        logic               ovf;
    } cplx_result_t;

    class cau_scoreboard;
        cplx_result_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Clamps an exact value to the 32-bit range and notes saturation.
        function logic signed [31:0] clamp(logic signed [129:0] v, ref logic ovf);
            if (v > 130'sh7FFFFFFF)
            begin
                ovf = 1'b1;
                return 32'sh7FFFFFFF;
            end
            if (v < -130'sh80000000)
            begin
                ovf = 1'b1;
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        // Quotient of exact numerator scaled by the fraction bits, toward zero.
        function logic signed [129:0] quot(logic signed [129:0] n, logic signed [129:0] d);
            logic signed [129:0] mag;
            logic signed [129:0] q;
            mag = (n < 0) ? -n : n;
            q = (mag <<< FRAC) / d;
            return (n < 0) ? -q : q;
        endfunction

        function void note_transfer(logic [1:0] k, logic signed [31:0] ar,
                                    logic signed [31:0] ai, logic signed [31:0] br,
                                    logic signed [31:0] bi);
            cplx_result_t r;
            logic signed [129:0] xr, xi, yr, yi, sr, si, d;
            xr = ar; xi = ai; yr = br; yi = bi;
            r.dz = 1'b0;
            r.ovf = 1'b0;
            r.re = '0;
            r.im = '0;
            case (k)
                KIND_ADD:
                begin
                    r.re = clamp(xr + yr, r.ovf);
                    r.im = clamp(xi + yi, r.ovf);
                end
                KIND_SUB:
                begin
                    r.re = clamp(xr - yr, r.ovf);
                    r.im = clamp(xi - yi, r.ovf);
                end
                KIND_MUL:
                begin
                    sr = xr * yr - xi * yi;
                    si = xi * yr + xr * yi;
                    r.re = clamp(sr >>> FRAC, r.ovf);
                    r.im = clamp(si >>> FRAC, r.ovf);
                end
                default:
                begin
                    d = yr * yr + yi * yi;
                    if (d == 0)
                        r.dz = 1'b1;
                    else
                    begin
                        sr = xr * yr + xi * yi;
                        si = xi * yr - xr * yi;
                        r.re = clamp(quot(sr, d), r.ovf);
                        r.im = clamp(quot(si, d), r.ovf);
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] re, logic signed [31:0] im,
                                   logic dz, logic ovf);
            cplx_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result re=%h im=%h", $time, re, im);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (re !== e.re)
            begin
                $display("%0t: res_re expected %h actual %h", $time, e.re, re);
                errors++;
            end
            if (im !== e.im)
            begin
                $display("%0t: res_im expected %h actual %h", $time, e.im, im);
                errors++;
            end
            if (dz !== e.dz)
            begin
                $display("%0t: div_zero expected %b actual %b", $time, e.dz, dz);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $display("%0t: overflow expected %b actual %b", $time, e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] kind = KIND_ADD;
    logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic done;
    logic signed [31:0] res_re, res_im;
    logic div_zero, overflow;
    longint cycles = 0;
    cau_scoreboard sb;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    complex_arith_unit #(.FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
        .res_re(res_re), .res_im(res_im), .div_zero(div_zero), .overflow(overflow)
    );

    initial sb = new();

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            sb.check_result(res_re, res_im, div_zero, overflow);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return '0;
            3: return $signed($urandom_range(0, 8)) - 4;
            4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            6: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [1:0] k, logic signed [31:0] ar, logic signed [31:0] ai,
                             logic signed [31:0] br, logic signed [31:0] bi, bit gaps);
        int idle;
        start <= 1'b1;
        kind <= k;
        a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
        do
            @(posedge clk);
        while (busy);
        sb.note_transfer(k, ar, ai, br, bi);
        if (gaps)
        begin
            idle = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 60)
                 : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
            if (idle > 0)
            begin
                start <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        logic signed [31:0] br, bi;
        int burst;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < 4; k++)
        begin
            send_item(2'(k), 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0);
            send_item(2'(k), 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0);
            send_item(2'(k), 32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, '0, 0);
            send_item(2'(k), -32'sh1, 32'sh3, 32'sh0000_0001, -32'sh0000_0001, 0);
        end
        send_item(KIND_DIV, 32'sh0001_0000, 32'sh1234, '0, '0, 0);
        send_item(KIND_DIV, 32'sh7FFFFFFF, 32'sh80000000, 32'sh1, '0, 0);
        send_item(KIND_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        send_item(KIND_MUL, 32'sh80000000, '0, 32'sh80000000, '0, 0);
        burst = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            br = pick_value();
            bi = ($urandom_range(0, 4) == 0) ? '0 : pick_value();
            if ($urandom_range(0, 40) == 0)
                br = '0;
            if (burst > 0)
                burst--;
            else if ($urandom_range(0, 30) == 0)
                burst = $urandom_range(20, 60);
            send_item(2'($urandom_range(0, 3)), pick_value(), pick_value(), br, bi,
                      burst == 0);
        end
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
